@@ rtl/mma_pkg.sv @@
package mma_pkg;

    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int FACTOR_W  = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 48;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_LOAD_C  = 2'd2,
        CMD_COMPUTE = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_M  = 2'd0,
        REG_COLS_N  = 2'd1,
        REG_INNER_K = 2'd2
    } t_reg;

    // travels with each A/B read through the MAC pipeline
    typedef struct packed {
        logic             first;
        logic             last;
        logic             final_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] value;
        logic             sat;
        logic             final_elem;
    } t_result;

endpackage

@@ rtl/mma_ram.sv @@
module mma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/mma_mac.sv @@
module mma_mac (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_adv,
    input  logic                                       i_valid,
    input  mma_pkg::t_tag                              i_tag,
    input  logic signed [mma_pkg::FACTOR_W-1:0]        i_a,
    input  logic signed [mma_pkg::FACTOR_W-1:0]        i_b,
    input  logic signed [mma_pkg::SUM_W-1:0]           i_c,
    output logic                                       o_busy,
    output logic                                       o_res_valid,
    output mma_pkg::t_result                           o_res
);

    localparam int PW = mma_pkg::PROD_W;
    localparam int SW = mma_pkg::SUM_W;

    logic                 r_valid;
    mma_pkg::t_tag        r_tag;
    logic signed [PW-1:0] r_prod;
    logic signed [SW-1:0] r_c;
    logic signed [SW-1:0] r_acc;
    logic                 r_sat;

    logic signed [SW-1:0] w_base;
    logic signed [SW:0]   w_sum;
    logic                 w_ovf;
    logic signed [SW-1:0] w_clip;
    logic                 w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= PW'(i_a) * PW'(i_b);
            r_c    <= i_c;
            r_tag  <= i_tag;
        end
    end

    // saturating accumulate, restarts from the C entry on the first product
    always_comb begin
        w_base = r_tag.first ? r_c : r_acc;
        w_sum  = (SW+1)'(w_base) + (SW+1)'(r_prod);
        w_ovf  = w_sum[SW] ^ w_sum[SW-1];
        if (w_ovf) begin
            w_clip = w_sum[SW] ? mma_pkg::SUM_MIN : mma_pkg::SUM_MAX;
        end else begin
            w_clip = w_sum[SW-1:0];
        end
        w_sat = (!r_tag.first && r_sat) || w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_valid) begin
            r_acc <= w_clip;
            r_sat <= w_sat;
        end
    end

    always_comb begin
        o_res.row        = r_tag.row;
        o_res.col        = r_tag.col;
        o_res.value      = w_clip;
        o_res.sat        = w_sat;
        o_res.final_elem = r_tag.final_elem;
    end

    assign o_res_valid = r_valid && r_tag.last;
    assign o_busy      = r_valid;

endmodule

@@ rtl/matrix_multiply_accumulate_core.sv @@
// Load word: written into its store at the accepting edge, no output.
// Compute word: walks rows, columns and the inner index, one A/B read pair per
// cycle unless the output stalls; elements come out row by row.
// During a run the input stalls until the MAC pipe is empty.
// Output stall freezes the read/MAC pipeline.
// Reset clears control and sets dimensions to 8; store contents are kept.
module matrix_multiply_accumulate_core #(
    parameter int MAX_DIM = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mma_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mma_pkg::DIM_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_command,
    input  logic [mma_pkg::IDX_W-1:0]           i_row_index,
    input  logic [mma_pkg::IDX_W-1:0]           i_col_index,
    input  logic signed [mma_pkg::FACTOR_W-1:0] i_factor_value,
    input  logic signed [mma_pkg::SUM_W-1:0]    i_sum_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mma_pkg::IDX_W-1:0]           o_out_row,
    output logic [mma_pkg::IDX_W-1:0]           o_out_col,
    output logic signed [mma_pkg::SUM_W-1:0]    o_out_value,
    output logic                                o_saturated,
    output logic                                o_last_item
);

    localparam int DIM_LIM = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int DEPTH   = DIM_LIM * DIM_LIM;
    localparam int IW      = $clog2(DIM_LIM);
    localparam int AW      = $clog2(DEPTH);
    localparam int DW      = mma_pkg::DIM_W;
    localparam int XW      = mma_pkg::IDX_W;
    localparam int FW      = mma_pkg::FACTOR_W;
    localparam int SW      = mma_pkg::SUM_W;
    localparam logic [DW-1:0] DIM_LIM_V = DW'(DIM_LIM);

    function automatic logic [IW-1:0] f_dim_last(input logic [DW-1:0] v);
        logic [IW-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > DIM_LIM_V) begin
            res = IW'(DIM_LIM - 1);
        end else begin
            res = IW'(v - 1'b1);
        end
        return res;
    endfunction

    logic [DW-1:0] r_rows_m;
    logic [DW-1:0] r_cols_n;
    logic [DW-1:0] r_inner_k;

    logic          r_busy;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_p;
    logic [IW-1:0] r_m_last;
    logic [IW-1:0] r_n_last;
    logic [IW-1:0] r_k_last;

    logic          r_s1_valid;
    mma_pkg::t_tag r_s1_tag;
    mma_pkg::t_tag w_iss_tag;

    logic             r_out_valid;
    mma_pkg::t_result r_out;

    logic             w_adv;
    logic             w_in_acc;
    logic             w_ld_ok;
    logic             w_ld_a;
    logic             w_ld_b;
    logic             w_ld_c;
    logic             w_start;
    logic             w_issue;
    logic [AW-1:0]    w_ld_addr;
    logic [AW-1:0]    w_a_rd_addr;
    logic [AW-1:0]    w_b_rd_addr;
    logic [AW-1:0]    w_c_rd_addr;
    logic [AW-1:0]    w_wb_addr;
    logic             w_c_we;
    logic [AW-1:0]    w_c_wr_addr;
    logic [SW-1:0]    w_c_wr_data;
    logic [FW-1:0]    w_a_data;
    logic [FW-1:0]    w_b_data;
    logic [SW-1:0]    w_c_data;
    logic             w_mac_busy;
    logic             w_res_valid;
    mma_pkg::t_result w_res;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m  <= DW'(8);
            r_cols_n  <= DW'(8);
            r_inner_k <= DW'(8);
        end else if (i_cfg_wr_en) begin
            case (mma_pkg::t_reg'(i_cfg_index))
                mma_pkg::REG_ROWS_M:  r_rows_m  <= i_cfg_data;
                mma_pkg::REG_COLS_N:  r_cols_n  <= i_cfg_data;
                mma_pkg::REG_INNER_K: r_inner_k <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_busy || r_s1_valid || w_mac_busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        w_ld_a  = 1'b0;
        w_ld_b  = 1'b0;
        w_ld_c  = 1'b0;
        w_start = 1'b0;
        w_ld_ok = (DW'(i_row_index) < DIM_LIM_V) && (DW'(i_col_index) < DIM_LIM_V);
        case (mma_pkg::t_cmd'(i_command))
            mma_pkg::CMD_LOAD_A:  w_ld_a  = w_in_acc && w_ld_ok;
            mma_pkg::CMD_LOAD_B:  w_ld_b  = w_in_acc && w_ld_ok;
            mma_pkg::CMD_LOAD_C:  w_ld_c  = w_in_acc && w_ld_ok;
            mma_pkg::CMD_COMPUTE: w_start = w_in_acc;
            default: ;
        endcase
    end

    assign w_ld_addr = AW'(int'(i_row_index) * DIM_LIM + int'(i_col_index));

    // read sequencer
    assign w_issue = w_adv && r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
            r_p    <= '0;
        end else if (w_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_j    <= '0;
            r_p    <= '0;
        end else if (w_issue) begin
            if (r_p == r_k_last) begin
                r_p <= '0;
                if (r_j == r_n_last) begin
                    r_j <= '0;
                    if (r_i == r_m_last) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end else begin
                r_p <= r_p + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_m_last <= f_dim_last(r_rows_m);
            r_n_last <= f_dim_last(r_cols_n);
            r_k_last <= f_dim_last(r_inner_k);
        end
    end

    assign w_a_rd_addr = AW'(int'(r_i) * DIM_LIM + int'(r_p));
    assign w_b_rd_addr = AW'(int'(r_p) * DIM_LIM + int'(r_j));
    assign w_c_rd_addr = AW'(int'(r_i) * DIM_LIM + int'(r_j));

    always_comb begin
        w_iss_tag.first      = (r_p == '0);
        w_iss_tag.last       = (r_p == r_k_last);
        w_iss_tag.final_elem = (r_i == r_m_last) && (r_j == r_n_last);
        w_iss_tag.row        = XW'(r_i);
        w_iss_tag.col        = XW'(r_j);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_tag <= w_iss_tag;
        end
    end

    // stores
    mma_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_a_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ld_a),
        .i_wr_addr (w_ld_addr),
        .i_wr_data (i_factor_value),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_a_rd_addr),
        .o_rd_data (w_a_data)
    );

    mma_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_b_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ld_b),
        .i_wr_addr (w_ld_addr),
        .i_wr_data (i_factor_value),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_b_rd_addr),
        .o_rd_data (w_b_data)
    );

    // loads and write-back never overlap: loads wait for an empty pipe
    assign w_wb_addr   = AW'(int'(w_res.row) * DIM_LIM + int'(w_res.col));
    assign w_c_we      = w_ld_c || (w_adv && w_res_valid);
    assign w_c_wr_addr = w_ld_c ? w_ld_addr : w_wb_addr;
    assign w_c_wr_data = w_ld_c ? i_sum_value : w_res.value;

    mma_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_c_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_c_we),
        .i_wr_addr (w_c_wr_addr),
        .i_wr_data (w_c_wr_data),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_c_rd_addr),
        .o_rd_data (w_c_data)
    );

    mma_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (r_s1_valid),
        .i_tag       (r_s1_tag),
        .i_a         (w_a_data),
        .i_b         (w_b_data),
        .i_c         (w_c_data),
        .o_busy      (w_mac_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out.row;
    assign o_out_col   = r_out.col;
    assign o_out_value = r_out.value;
    assign o_saturated = r_out.sat;
    assign o_last_item = r_out.final_elem;

endmodule

@@ rtl/mma_chk.sv @@
module mma_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [1:0]                       i_command,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [mma_pkg::IDX_W-1:0]        o_out_row,
    input logic [mma_pkg::IDX_W-1:0]        o_out_col,
    input logic [mma_pkg::SUM_W-1:0]        o_out_value,
    input logic                             o_saturated,
    input logic                             o_last_item
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_row) && $stable(o_out_col)
            && $stable(o_out_value) && $stable(o_saturated) && $stable(o_last_item))
        else $error("output word changed under stall");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_command == mma_pkg::CMD_COMPUTE) |=> o_in_stall)
        else $error("input not stalled after compute word");

    a_load_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_command != mma_pkg::CMD_COMPUTE) |=> !$rose(o_out_valid))
        else $error("output word appeared after a load");

endmodule

bind matrix_multiply_accumulate_core mma_chk u_mma_chk (.*);
